FILE: src/ofq_pkg.sv
// Package for the output fault qualifier: codes, fault kinds, register
// indexes, reset values and the structs shared by the top level and the
// evaluation logic. Depends on nothing.
package ofq_pkg;

   // Latched error codes.
   typedef enum logic [2:0] {
      CODE_NONE     = 3'd0,
      CODE_OVERVOLT = 3'd1,
      CODE_SHORT    = 3'd2,
      CODE_OPEN     = 3'd3,
      CODE_START    = 3'd4
   } code_type;

   // Kind of output fault seen on the last checked tick.
   typedef enum logic [1:0] {
      KIND_SHORT = 2'd0,
      KIND_OPEN  = 2'd1,
      KIND_START = 2'd2
   } kind_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_BLANKING_TICKS  = 3'd0,
      CSR_OVERVOLT_MV     = 3'd1,
      CSR_SHORT_MARGIN_MV = 3'd2,
      CSR_START_FLOOR_MV  = 3'd3,
      CSR_OPEN_CEILING_MV = 3'd4
   } csr_index_type;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 15;

   // Field widths.
   localparam int unsigned TicksWidth = 8;
   localparam int unsigned BattWidth  = 13;
   localparam int unsigned RailWidth  = 15;
   localparam int unsigned LevelWidth = 4;

   // Leaky counter stops adding at this level and reports from it upwards.
   localparam logic [LevelWidth-1:0] LevelLimit = 4'd8;

   // Register values after reset.
   localparam logic [TicksWidth-1:0] BlankingTicksReset = 8'd8;
   localparam logic [BattWidth-1:0]  OvervoltReset      = 13'd4350;
   localparam logic [BattWidth-1:0]  ShortMarginReset   = 13'd1000;
   localparam logic [RailWidth-1:0]  StartFloorReset    = 15'd11100;
   localparam logic [RailWidth-1:0]  OpenCeilingReset   = 15'd17000;

   // Stream payload widths in bits, padded to whole bytes.
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 8;

   typedef struct packed {
      logic [TicksWidth-1:0] blanking_ticks;
      logic [BattWidth-1:0]  overvolt_mv;
      logic [BattWidth-1:0]  short_margin_mv;
      logic [RailWidth-1:0]  start_floor_mv;
      logic [RailWidth-1:0]  open_ceiling_mv;
   } cfg_type;

   typedef struct packed {
      logic                 output_on;
      logic [BattWidth-1:0] battery_mv;
      logic [RailWidth-1:0] raw_battery_mv;
      logic [RailWidth-1:0] output_mv;
      logic                 clear_error;
   } sample_type;

   typedef struct packed {
      logic [TicksWidth-1:0] blank_count;
      logic [LevelWidth-1:0] fault_level;
      kind_type              fault_kind;
      code_type              latched_code;
   } state_type;

   typedef struct packed {
      logic     report;
      code_type error_code;
      logic     fatal;
   } result_type;

endpackage

FILE: src/output_fault_qualifier.sv
// Output fault qualifier, top level. A request passes through the input register and then the
// result register before its result is offered; the result register holds it while the
// result stream stalls. Throughput: one transfer per cycle while rsp_tready is high, set by the
// combinational decision logic between the two registers.
// Synchronous active-high reset clears the pipeline, fault state and error
// code, and restores the configuration registers to their defaults.
module output_fault_qualifier (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] output_on, [13:1] battery_mv, [28:14] raw_battery_mv,
   // [43:29] output_mv, [44] clear_error, [47:45] zero
   input  logic [ofq_pkg::ReqDataWidth-1:0]    req_tdata,
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] report, [3:1] error_code, [4] fatal, [7:5] zero
   output logic [ofq_pkg::RspDataWidth-1:0]    rsp_tdata,
   // Configuration write port.
   input  logic                                csr_wr_en,
   input  logic [ofq_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [ofq_pkg::CsrDataWidth-1:0]    csr_wr_data
);

   ofq_pkg::cfg_type    cfg_ff;
   ofq_pkg::sample_type sample_ff;
   ofq_pkg::sample_type sample_in;
   logic                sample_valid_ff;
   ofq_pkg::state_type  state_ff;
   ofq_pkg::state_type  state_in;
   ofq_pkg::result_type result_in;
   ofq_pkg::result_type result_ff;
   logic                result_valid_ff;
   logic                advance;

   // Unpack the request payload.
   assign sample_in.output_on      = req_tdata[0];
   assign sample_in.battery_mv     = req_tdata[13:1];
   assign sample_in.raw_battery_mv = req_tdata[28:14];
   assign sample_in.output_mv      = req_tdata[43:29];
   assign sample_in.clear_error    = req_tdata[44];

   // An item moves to the result register when that register is free or
   // is being emptied in this cycle.
   assign advance    = sample_valid_ff && (!result_valid_ff || rsp_tready);
   assign req_tready = !sample_valid_ff || advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blanking_ticks  <= ofq_pkg::BlankingTicksReset;
         cfg_ff.overvolt_mv     <= ofq_pkg::OvervoltReset;
         cfg_ff.short_margin_mv <= ofq_pkg::ShortMarginReset;
         cfg_ff.start_floor_mv  <= ofq_pkg::StartFloorReset;
         cfg_ff.open_ceiling_mv <= ofq_pkg::OpenCeilingReset;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            ofq_pkg::CSR_BLANKING_TICKS:
               cfg_ff.blanking_ticks <= csr_wr_data[ofq_pkg::TicksWidth-1:0];
            ofq_pkg::CSR_OVERVOLT_MV:
               cfg_ff.overvolt_mv <= csr_wr_data[ofq_pkg::BattWidth-1:0];
            ofq_pkg::CSR_SHORT_MARGIN_MV:
               cfg_ff.short_margin_mv <= csr_wr_data[ofq_pkg::BattWidth-1:0];
            ofq_pkg::CSR_START_FLOOR_MV:
               cfg_ff.start_floor_mv <= csr_wr_data[ofq_pkg::RailWidth-1:0];
            ofq_pkg::CSR_OPEN_CEILING_MV:
               cfg_ff.open_ceiling_mv <= csr_wr_data[ofq_pkg::RailWidth-1:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
      end else if (req_tready) begin
         sample_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= sample_in;
      end
   end

   ofq_eval u_eval (
      .cfg        (cfg_ff),
      .sample     (sample_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   // Fault state advances once per item that leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.blank_count  <= '0;
         state_ff.fault_level  <= '0;
         state_ff.fault_kind   <= ofq_pkg::KIND_SHORT;
         state_ff.latched_code <= ofq_pkg::CODE_NONE;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         result_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = {3'b000, result_ff.fatal, result_ff.error_code, result_ff.report};

   // The leaky counter never climbs past one step above its limit.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.fault_level <= ofq_pkg::LevelLimit + 4'd1)
      else $error("fault level above its ceiling");

   // A reported fault always leaves a code latched.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result_ff.report) |-> (result_ff.error_code != ofq_pkg::CODE_NONE))
      else $error("report without a latched code");

   // The fatal flag agrees with the code it is offered with.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result_ff.fatal == !(result_ff.error_code == ofq_pkg::CODE_OVERVOLT
         || result_ff.error_code == ofq_pkg::CODE_SHORT
         || result_ff.error_code == ofq_pkg::CODE_OPEN)))
      else $error("fatal flag does not match error code");

   // Fault state changes only when an item is processed.
   assert property (@(posedge clock) disable iff (reset)
      (!advance && !$past(reset)) |=> $stable(state_ff))
      else $error("fault state changed without an item");

   // The result code is the code that stays latched afterwards.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (state_ff.latched_code == result_ff.error_code))
      else $error("result code differs from latched code");

endmodule

FILE: src/ofq_eval.sv
// Decision logic for one tick of the output fault qualifier: blanking,
// overvoltage, the leaky fault counter and the latched code.
// Depends on ofq_pkg.
module ofq_eval (
   input  ofq_pkg::cfg_type    cfg,
   input  ofq_pkg::sample_type sample,
   input  ofq_pkg::state_type  state,
   output ofq_pkg::state_type  state_next,
   output ofq_pkg::result_type result
);

   logic [ofq_pkg::RailWidth:0]    short_sum;
   logic                           is_short;
   logic                           is_start;
   logic                           is_open;
   logic [ofq_pkg::LevelWidth-1:0] level;
   ofq_pkg::code_type              code;

   // Short when output plus margin stays below the raw rail; a margin
   // above the rail can never satisfy this, as required.
   assign short_sum = {1'b0, sample.output_mv}
                    + {{(ofq_pkg::RailWidth + 1 - ofq_pkg::BattWidth){1'b0}},
                       cfg.short_margin_mv};
   assign is_short  = short_sum < {1'b0, sample.raw_battery_mv};
   assign is_start  = sample.output_mv < cfg.start_floor_mv;
   assign is_open   = sample.output_mv > cfg.open_ceiling_mv;

   // Next state and result for the tick.
   always_comb begin
      state_next    = state;
      level         = state.fault_level;
      code          = sample.clear_error ? ofq_pkg::CODE_NONE : state.latched_code;
      result.report = 1'b0;

      if (!sample.output_on) begin
         state_next.blank_count = '0;
      end else if (state.blank_count < cfg.blanking_ticks) begin
         state_next.blank_count = state.blank_count + 8'd1;
      end else begin
         if (sample.battery_mv > cfg.overvolt_mv) begin
            code          = ofq_pkg::CODE_OVERVOLT;
            result.report = 1'b1;
         end

         if (is_short) begin
            level = (state.fault_level < ofq_pkg::LevelLimit) ?
                    state.fault_level + 4'd2 : ofq_pkg::LevelLimit;
            state_next.fault_kind = ofq_pkg::KIND_SHORT;
         end else if (is_start) begin
            level = (state.fault_level < ofq_pkg::LevelLimit) ?
                    state.fault_level + 4'd1 : ofq_pkg::LevelLimit;
            state_next.fault_kind = ofq_pkg::KIND_START;
         end else if (is_open) begin
            level = (state.fault_level < ofq_pkg::LevelLimit) ?
                    state.fault_level + 4'd1 : ofq_pkg::LevelLimit;
            state_next.fault_kind = ofq_pkg::KIND_OPEN;
         end else begin
            level = (state.fault_level != '0) ? state.fault_level - 4'd1 : '0;
            state_next.fault_kind = ofq_pkg::KIND_SHORT;
         end
         state_next.fault_level = level;

         // A qualified output fault overrides an overvoltage in the same tick.
         if (level >= ofq_pkg::LevelLimit) begin
            result.report = 1'b1;
            case (state_next.fault_kind)
               ofq_pkg::KIND_OPEN:  code = ofq_pkg::CODE_OPEN;
               ofq_pkg::KIND_START: code = ofq_pkg::CODE_START;
               default:             code = ofq_pkg::CODE_SHORT;
            endcase
         end
      end

      state_next.latched_code = code;
      result.error_code       = code;
      case (code)
         ofq_pkg::CODE_OVERVOLT,
         ofq_pkg::CODE_SHORT,
         ofq_pkg::CODE_OPEN: result.fatal = 1'b0;
         default:            result.fatal = 1'b1;
      endcase
   end

endmodule
